### sv/rc4kg_pkg.sv
// Shared types and constants of the RC4 keystream generator.
`default_nettype none

package rc4kg_pkg;

  localparam int PERM_DEPTH = 256;
  localparam int IDX_W      = 8;
  localparam int CNT_W      = 30;
  localparam int KIND_W     = 2;
  localparam int BCNT_W     = 4;

  localparam logic [KIND_W-1:0] KIND_RESTART  = 2'd0;
  localparam logic [KIND_W-1:0] KIND_KEY_STEP = 2'd1;
  localparam logic [KIND_W-1:0] KIND_GENERATE = 2'd2;

  typedef enum logic [3:0] {
    ST_SWEEP,
    ST_IDLE,
    ST_KS_J,
    ST_KS_WP,
    ST_KS_WJ,
    ST_G_J,
    ST_G_WI,
    ST_G_WJ,
    ST_G_RK,
    ST_G_OUT
  } state_t;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_CLEAR,
    OP_SWEEP,
    OP_KEY_LOAD,
    OP_KEY_J,
    OP_KEY_WP,
    OP_KEY_WJ,
    OP_GEN_LOAD,
    OP_GEN_J,
    OP_GEN_WI,
    OP_GEN_WJ,
    OP_GEN_RK,
    OP_GEN_OUT
  } op_t;

  typedef struct packed {
    op_t  op;
    logic last;
  } cmd_t;

  typedef struct packed {
    logic sweep_last;
  } status_t;

endpackage

`default_nettype wire

### sv/rc4kg_ram.sv
// Generic single-write, single-read RAM with a registered read port.
`default_nettype none

module rc4kg_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

`default_nettype wire

### sv/rc4kg_ctrl.sv
// Controller state machine that sequences restart, key steps and generate runs.
`default_nettype none

module rc4kg_ctrl #(
  parameter int MAX_RUN = 8,
  parameter int RUN_W   = $clog2(MAX_RUN + 1)
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          start,
  input  wire logic [rc4kg_pkg::KIND_W-1:0]  in_kind,
  input  wire logic [rc4kg_pkg::BCNT_W-1:0]  in_byte_count,
  input  wire rc4kg_pkg::status_t            status,
  output logic                               busy,
  output rc4kg_pkg::cmd_t                    cmd,
  output logic      [RUN_W-1:0]              run_len
);

  localparam int CMP_W = (RUN_W > rc4kg_pkg::BCNT_W) ? RUN_W : rc4kg_pkg::BCNT_W;
  localparam logic [CMP_W-1:0] MAX_CMP = CMP_W'(MAX_RUN);

  rc4kg_pkg::state_t state_r, state_nxt;
  logic [RUN_W-1:0]  rem_r, rem_nxt;
  logic [CMP_W-1:0]  cnt_ext;

  assign cnt_ext = CMP_W'(in_byte_count);
  assign run_len = (cnt_ext > MAX_CMP) ? RUN_W'(MAX_RUN) : RUN_W'(in_byte_count);
  assign busy    = (state_r != rc4kg_pkg::ST_IDLE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= rc4kg_pkg::ST_SWEEP;
      rem_r   <= '0;
    end else begin
      state_r <= state_nxt;
      rem_r   <= rem_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    rem_nxt   = rem_r;
    cmd.op    = rc4kg_pkg::OP_NONE;
    cmd.last  = 1'b0;
    unique case (state_r)
      rc4kg_pkg::ST_SWEEP: begin
        cmd.op = rc4kg_pkg::OP_SWEEP;
        if (status.sweep_last) begin
          state_nxt = rc4kg_pkg::ST_IDLE;
        end
      end
      rc4kg_pkg::ST_IDLE: begin
        if (start) begin
          unique case (in_kind)
            rc4kg_pkg::KIND_RESTART: begin
              cmd.op    = rc4kg_pkg::OP_CLEAR;
              state_nxt = rc4kg_pkg::ST_SWEEP;
            end
            rc4kg_pkg::KIND_KEY_STEP: begin
              cmd.op    = rc4kg_pkg::OP_KEY_LOAD;
              state_nxt = rc4kg_pkg::ST_KS_J;
            end
            rc4kg_pkg::KIND_GENERATE: begin
              if (in_byte_count != '0) begin
                cmd.op    = rc4kg_pkg::OP_GEN_LOAD;
                rem_nxt   = run_len;
                state_nxt = rc4kg_pkg::ST_G_J;
              end
            end
            default: begin
              state_nxt = rc4kg_pkg::ST_IDLE;
            end
          endcase
        end
      end
      rc4kg_pkg::ST_KS_J: begin
        cmd.op    = rc4kg_pkg::OP_KEY_J;
        state_nxt = rc4kg_pkg::ST_KS_WP;
      end
      rc4kg_pkg::ST_KS_WP: begin
        cmd.op    = rc4kg_pkg::OP_KEY_WP;
        state_nxt = rc4kg_pkg::ST_KS_WJ;
      end
      rc4kg_pkg::ST_KS_WJ: begin
        cmd.op    = rc4kg_pkg::OP_KEY_WJ;
        state_nxt = rc4kg_pkg::ST_IDLE;
      end
      rc4kg_pkg::ST_G_J: begin
        cmd.op    = rc4kg_pkg::OP_GEN_J;
        state_nxt = rc4kg_pkg::ST_G_WI;
      end
      rc4kg_pkg::ST_G_WI: begin
        cmd.op    = rc4kg_pkg::OP_GEN_WI;
        state_nxt = rc4kg_pkg::ST_G_WJ;
      end
      rc4kg_pkg::ST_G_WJ: begin
        cmd.op    = rc4kg_pkg::OP_GEN_WJ;
        state_nxt = rc4kg_pkg::ST_G_RK;
      end
      rc4kg_pkg::ST_G_RK: begin
        cmd.op    = rc4kg_pkg::OP_GEN_RK;
        state_nxt = rc4kg_pkg::ST_G_OUT;
      end
      rc4kg_pkg::ST_G_OUT: begin
        cmd.op   = rc4kg_pkg::OP_GEN_OUT;
        cmd.last = (rem_r == RUN_W'(1));
        rem_nxt  = rem_r - RUN_W'(1);
        if (cmd.last) begin
          state_nxt = rc4kg_pkg::ST_IDLE;
        end else begin
          state_nxt = rc4kg_pkg::ST_G_J;
        end
      end
      default: begin
        state_nxt = rc4kg_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

### sv/rc4kg_dp.sv
// Datapath with the permutation memory, indices, byte counter and result registers.
`default_nettype none

module rc4kg_dp #(
  parameter int RUN_W = 4
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire rc4kg_pkg::cmd_t              cmd,
  input  wire logic [RUN_W-1:0]             run_len,
  input  wire logic [rc4kg_pkg::IDX_W-1:0]  in_key_byte,
  output rc4kg_pkg::status_t                status,
  output logic                              out_valid,
  output logic      [rc4kg_pkg::IDX_W-1:0]  out_random_byte,
  output logic                              out_last,
  output logic                              out_need_rekey
);

  localparam int IW = rc4kg_pkg::IDX_W;
  localparam int CW = rc4kg_pkg::CNT_W;

  logic [IW-1:0] i_r, i_nxt;
  logic [IW-1:0] j_r, j_nxt;
  logic [IW-1:0] kp_r, kp_nxt;
  logic [IW-1:0] sw_r, sw_nxt;
  logic [CW-1:0] pc_r, pc_nxt;
  logic [IW-1:0] kb_r, kb_nxt;
  logic [IW-1:0] t_r, t_nxt;
  logic [IW-1:0] u_r, u_nxt;
  logic          rekey_r, rekey_nxt;
  logic          ov_r, ov_nxt;
  logic [IW-1:0] ob_r, ob_nxt;
  logic          ol_r, ol_nxt;

  logic          we;
  logic [IW-1:0] wr_addr;
  logic [IW-1:0] wr_data;
  logic [IW-1:0] rd_addr;
  logic [IW-1:0] rd_data;

  rc4kg_ram #(
    .WIDTH (IW),
    .DEPTH (rc4kg_pkg::PERM_DEPTH)
  ) u_perm (
    .clk     (clk),
    .we      (we),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  assign status.sweep_last = (sw_r == {IW{1'b1}});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      i_r     <= '0;
      j_r     <= '0;
      kp_r    <= '0;
      sw_r    <= '0;
      pc_r    <= '0;
      ov_r    <= 1'b0;
    end else begin
      i_r     <= i_nxt;
      j_r     <= j_nxt;
      kp_r    <= kp_nxt;
      sw_r    <= sw_nxt;
      pc_r    <= pc_nxt;
      ov_r    <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    kb_r    <= kb_nxt;
    t_r     <= t_nxt;
    u_r     <= u_nxt;
    rekey_r <= rekey_nxt;
    ob_r    <= ob_nxt;
    ol_r    <= ol_nxt;
  end

  always_comb begin
    i_nxt     = i_r;
    j_nxt     = j_r;
    kp_nxt    = kp_r;
    sw_nxt    = sw_r;
    pc_nxt    = pc_r;
    kb_nxt    = kb_r;
    t_nxt     = t_r;
    u_nxt     = u_r;
    rekey_nxt = rekey_r;
    ov_nxt    = 1'b0;
    ob_nxt    = ob_r;
    ol_nxt    = ol_r;
    we        = 1'b0;
    wr_addr   = sw_r;
    wr_data   = sw_r;
    rd_addr   = i_r;
    unique case (cmd.op)
      rc4kg_pkg::OP_NONE: begin
        rd_addr = i_r;
      end
      rc4kg_pkg::OP_CLEAR: begin
        i_nxt  = '0;
        j_nxt  = '0;
        kp_nxt = '0;
        sw_nxt = '0;
      end
      rc4kg_pkg::OP_SWEEP: begin
        we     = 1'b1;
        sw_nxt = sw_r + IW'(1);
      end
      rc4kg_pkg::OP_KEY_LOAD: begin
        kb_nxt  = in_key_byte;
        rd_addr = kp_r;
      end
      rc4kg_pkg::OP_KEY_J: begin
        j_nxt   = j_r + rd_data + kb_r;
        t_nxt   = rd_data;
        rd_addr = j_nxt;
      end
      rc4kg_pkg::OP_KEY_WP: begin
        we      = 1'b1;
        wr_addr = kp_r;
        wr_data = rd_data;
      end
      rc4kg_pkg::OP_KEY_WJ: begin
        we      = 1'b1;
        wr_addr = j_r;
        wr_data = t_r;
        kp_nxt  = kp_r + IW'(1);
        if (kp_r == {IW{1'b1}}) begin
          j_nxt = '0;
        end
      end
      rc4kg_pkg::OP_GEN_LOAD: begin
        rekey_nxt = (pc_r == '0);
        pc_nxt    = pc_r + CW'(run_len);
        i_nxt     = i_r + IW'(1);
        rd_addr   = i_nxt;
      end
      rc4kg_pkg::OP_GEN_J: begin
        t_nxt   = rd_data;
        j_nxt   = j_r + rd_data;
        rd_addr = j_nxt;
      end
      rc4kg_pkg::OP_GEN_WI: begin
        we      = 1'b1;
        wr_addr = i_r;
        wr_data = rd_data;
        u_nxt   = rd_data;
      end
      rc4kg_pkg::OP_GEN_WJ: begin
        we      = 1'b1;
        wr_addr = j_r;
        wr_data = t_r;
      end
      rc4kg_pkg::OP_GEN_RK: begin
        rd_addr = t_r + u_r;
      end
      rc4kg_pkg::OP_GEN_OUT: begin
        ov_nxt = 1'b1;
        ob_nxt = rd_data;
        ol_nxt = cmd.last;
        if (!cmd.last) begin
          i_nxt   = i_r + IW'(1);
          rd_addr = i_nxt;
        end
      end
      default: begin
        rd_addr = i_r;
      end
    endcase
  end

  assign out_valid       = ov_r;
  assign out_random_byte = ob_r;
  assign out_last        = ol_r;
  assign out_need_rekey  = rekey_r;

endmodule

`default_nettype wire

### sv/rc4_keystream_generator.sv
// Top level of the RC4 keystream generator: controller plus datapath.
//
//   channel | ports                                       | handshake
//   --------+---------------------------------------------+----------------------------
//   input   | in_kind, in_key_byte, in_byte_count         | accepted when start && !busy
//   result  | out_random_byte, out_last, out_need_rekey   | out_valid strobe, one cycle
//
// A key-byte item steps through ST_KS_J, ST_KS_WP and ST_KS_WJ, and a generate item of n
// bytes through ST_G_J, ST_G_WI, ST_G_WJ, ST_G_RK and ST_G_OUT for each byte, as set by
// the dependent reads and swap writes on the permutation memory. Restart and reset each
// load the identity into all 256 memory entries, one entry per cycle, with busy high.
// Each result appears on the output ports in the cycle after it is read from memory.
// The receiver cannot stall, so results are never held back.
`default_nettype none

module rc4_keystream_generator #(
  parameter int MAX_RUN = 8
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       start,
  output logic            busy,
  input  wire logic [1:0] in_kind,
  input  wire logic [7:0] in_key_byte,
  input  wire logic [3:0] in_byte_count,
  output logic            out_valid,
  output logic      [7:0] out_random_byte,
  output logic            out_last,
  output logic            out_need_rekey
);

  localparam int RUN_W = $clog2(MAX_RUN + 1);

  rc4kg_pkg::cmd_t    cmd;
  rc4kg_pkg::status_t status;
  logic [RUN_W-1:0]   run_len;

  rc4kg_ctrl #(
    .MAX_RUN (MAX_RUN),
    .RUN_W   (RUN_W)
  ) u_ctrl (
    .clk           (clk),
    .rst_n         (rst_n),
    .start         (start),
    .in_kind       (in_kind),
    .in_byte_count (in_byte_count),
    .status        (status),
    .busy          (busy),
    .cmd           (cmd),
    .run_len       (run_len)
  );

  rc4kg_dp #(
    .RUN_W (RUN_W)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .run_len         (run_len),
    .in_key_byte     (in_key_byte),
    .status          (status),
    .out_valid       (out_valid),
    .out_random_byte (out_random_byte),
    .out_last        (out_last),
    .out_need_rekey  (out_need_rekey)
  );

endmodule

`default_nettype wire
